[hdl/trs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_pkg: shared types and constants for the temperature report scheduler
// Word formats between the front and back parts, register indexes, cause
// codes and the fixed codes that the readings use.
// ----------------------------------------------------------------------------
package trs_pkg;

	localparam int unsigned ValW   = 16;
	localparam int unsigned MagW   = 11;
	localparam int unsigned IvW    = 16;
	localparam int unsigned CountW = 8;
	localparam int unsigned CauseW = 3;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;

	// Default queue depths
	localparam int unsigned MidDepthDef = 4;
	localparam int unsigned OutDepthDef = 4;

	// Fixed codes
	localparam logic [ValW-1:0] SignMask  = 16'hE000;
	localparam logic [ValW-1:0] SuspectLo = 16'd850;
	localparam logic [ValW-1:0] ErrorLo   = 16'd4017;
	localparam logic [ValW-1:0] SuspectHi = 16'd1250;
	localparam logic [ValW-1:0] ErrorHi   = 16'd4018;

	// Register indexes
	localparam logic [CfgIdxW-1:0] RegNormalIv  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegAlarmIv   = 3'd1;
	localparam logic [CfgIdxW-1:0] RegPeriod    = 3'd2;
	localparam logic [CfgIdxW-1:0] RegAlarmLim  = 3'd3;
	localparam logic [CfgIdxW-1:0] RegJumpLim   = 3'd4;

	// Cause codes
	localparam logic [CauseW-1:0] CauseHold   = 3'd0;
	localparam logic [CauseW-1:0] CauseNormal = 3'd1;
	localparam logic [CauseW-1:0] CauseAlarm  = 3'd2;
	localparam logic [CauseW-1:0] CauseFail   = 3'd3;
	localparam logic [CauseW-1:0] CauseJump   = 3'd4;

	// Configuration registers
	typedef struct packed {
		logic [IvW-1:0]  normal_iv;
		logic [IvW-1:0]  alarm_iv;
		logic [IvW-1:0]  period;
		logic [MagW-1:0] alarm_lim;
		logic [MagW-1:0] jump_lim;
	} cfg_t;

	// Classified sample, front to back
	typedef struct packed {
		logic [ValW-1:0] value;
		logic            ok;
		logic            jump;
		logic            alarm;
	} mid_t;

	// Result word
	typedef struct packed {
		logic              send;
		logic [ValW-1:0]   value;
		logic [CauseW-1:0] cause;
	} res_t;

endpackage

[hdl/trs_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_fifo: small register queue
// Holds up to DEPTH words; the head word is presented while empty is low.
// ----------------------------------------------------------------------------
module trs_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == FullCnt);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/trs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_front: sample classifier
// Median of three, code rewrite, step from the previous value, and the
// jump and alarm flags for the back part.
// ----------------------------------------------------------------------------
module trs_front import trs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            accept,
	input  logic [ValW-1:0] reading_first,
	input  logic [ValW-1:0] reading_second,
	input  logic [ValW-1:0] reading_third,
	input  logic            read_ok,
	output mid_t            mid
);

	logic [ValW-1:0] prev_q;
	logic [ValW-1:0] lo, hi, med, value;
	logic [ValW-1:0] step;
	logic [MagW-1:0] wrap_sum;

	// Median of three
	always_comb begin
		lo = (reading_first < reading_second) ? reading_first : reading_second;
		hi = (reading_first < reading_second) ? reading_second : reading_first;
		if (reading_third <= lo) begin
			med = lo;
		end else if (reading_third >= hi) begin
			med = hi;
		end else begin
			med = reading_third;
		end
	end

	// Suspect codes become error codes
	always_comb begin
		if (med == SuspectLo) begin
			value = ErrorLo;
		end else if (med == SuspectHi) begin
			value = ErrorHi;
		end else begin
			value = med;
		end
	end

	// Step: across a sign change it is the masked sum of magnitudes
	always_comb begin
		wrap_sum = value[MagW-1:0] + prev_q[MagW-1:0];
		if (((value ^ prev_q) & SignMask) != '0) begin
			step = {{(ValW-MagW){1'b0}}, wrap_sum};
		end else if (value >= prev_q) begin
			step = value - prev_q;
		end else begin
			step = prev_q - value;
		end
	end

	always_comb begin
		mid.value = value;
		mid.ok    = read_ok;
		mid.jump  = (step >= {{(ValW-MagW){1'b0}}, cfg.jump_lim});
		mid.alarm = (value[MagW-1:0] >= cfg.alarm_lim);
	end

	// Previous value follows every accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (accept) begin
			prev_q <= value;
		end
	end

endmodule

[hdl/trs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_back: report decision
// Elapsed time against the selected interval, cause code and the
// saturating sample count.
// ----------------------------------------------------------------------------
module trs_back import trs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic fire,
	input  mid_t mid,
	output res_t res
);

	localparam logic [CountW-1:0] CountOne = CountW'(1);
	localparam logic [CountW-1:0] CountMax = '1;
	localparam int unsigned       ProdW    = CountW + IvW;

	logic [CountW-1:0] count_q;
	logic [ProdW-1:0]  elapsed;
	logic [IvW-1:0]    limit;
	logic              due;

	// Elapsed time against the interval in force
	always_comb begin
		elapsed = ProdW'(count_q) * ProdW'(cfg.period);
		limit   = mid.alarm ? cfg.alarm_iv : cfg.normal_iv;
		due     = (elapsed >= ProdW'(limit));
	end

	// Cause priority: failure, jump, interval
	always_comb begin
		res.value = mid.value;
		if (!mid.ok) begin
			res.send  = 1'b1;
			res.cause = CauseFail;
		end else if (mid.jump) begin
			res.send  = 1'b1;
			res.cause = CauseJump;
		end else if (due) begin
			res.send  = 1'b1;
			res.cause = mid.alarm ? CauseAlarm : CauseNormal;
		end else begin
			res.send  = 1'b0;
			res.cause = CauseHold;
		end
	end

	// Sample count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CountOne;
		end else if (fire) begin
			if (res.send) begin
				count_q <= CountOne;
			end else if (count_q != CountMax) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0) else $error("sample count reached zero");

	a_send_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.send |=> count_q == CountOne)
		else $error("count not restarted after a report");

	a_hold_counts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !res.send && count_q != CountMax |=> count_q == $past(count_q) + 1'b1)
		else $error("count did not advance on hold");

	// Only a word actually taken from the middle queue carries valid fields
	a_cause_send: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> res.send == (res.cause != CauseHold))
		else $error("cause and send disagree");

endmodule

[hdl/temperature_report_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_report_scheduler: report decision per temperature sample
// Filters three readings, tracks the step and the time since the last
// report, and tells per sample whether and why a report is due.
// ----------------------------------------------------------------------------
// One sample is taken every clock cycle while full is low and yields one
// result word: the front writes it into the middle queue at the accepting
// edge, the back part into the result queue, where it can be popped. The
// rate is set by the back part's loop on the sample count: one multiply of
// count by period, a compare and the count update per cycle while the middle
// queue holds a word and the result queue is not full. Both queues are
// MID_DEPTH and OUT_DEPTH words deep, so either side may stall on its own;
// full is the middle queue's full flag. Write configuration only while idle.
// ----------------------------------------------------------------------------
module temperature_report_scheduler import trs_pkg::*; #(
	parameter int unsigned MID_DEPTH = MidDepthDef,
	parameter int unsigned OUT_DEPTH = OutDepthDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                push,
	output logic                full,
	input  logic [ValW-1:0]     reading_first,
	input  logic [ValW-1:0]     reading_second,
	input  logic [ValW-1:0]     reading_third,
	input  logic                read_ok,
	input  logic                pop,
	output logic                empty,
	output logic                send_now,
	output logic [ValW-1:0]     report_value,
	output logic [CauseW-1:0]   cause
);

	cfg_t cfg_q;
	mid_t mid_in, mid_out;
	res_t res_in, res_out;
	logic in_accept, mid_empty, out_full, back_fire;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_iv <= IvW'(300);
			cfg_q.alarm_iv  <= IvW'(60);
			cfg_q.period    <= IvW'(60);
			cfg_q.alarm_lim <= MagW'(750);
			cfg_q.jump_lim  <= MagW'(20);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				RegNormalIv: cfg_q.normal_iv <= cfg_data[IvW-1:0];
				RegAlarmIv:  cfg_q.alarm_iv  <= cfg_data[IvW-1:0];
				RegPeriod:   cfg_q.period    <= cfg_data[IvW-1:0];
				RegAlarmLim: cfg_q.alarm_lim <= cfg_data[MagW-1:0];
				RegJumpLim:  cfg_q.jump_lim  <= cfg_data[MagW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_accept = push && !full;
	assign back_fire = !mid_empty && !out_full;

	// Front: classify
	trs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.accept         (in_accept),
		.reading_first  (reading_first),
		.reading_second (reading_second),
		.reading_third  (reading_third),
		.read_ok        (read_ok),
		.mid            (mid_in)
	);

	// Queue between front and back
	trs_fifo #(
		.WIDTH ($bits(mid_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_accept),
		.wr_data (mid_in),
		.full    (full),
		.rd_en   (back_fire),
		.rd_data (mid_out),
		.empty   (mid_empty)
	);

	// Back: decide
	trs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.fire   (back_fire),
		.mid    (mid_out),
		.res    (res_in)
	);

	// Result queue
	trs_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (back_fire),
		.wr_data (res_in),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign send_now     = res_out.send;
	assign report_value = res_out.value;
	assign cause        = res_out.cause;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: randomized check of the temperature report scheduler
// Feeds triples of raw readings through the push/full side and drains result
// words through the pop/empty side, with random stalls on both. A scoreboard
// object keeps its own copy of the settings, the stored value and the sample
// count, predicts one word per accepted sample and compares each popped word
// against the oldest prediction.
// ----------------------------------------------------------------------------
import trs_pkg::*;

localparam logic [ValW-1:0]   MagMask  = 16'h07FF;
localparam logic [CountW-1:0] CountMax = 8'hFF;

// Predicts the report word for each accepted sample and checks popped words
class report_scoreboard;
	logic [IvW-1:0]    normal_iv;
	logic [IvW-1:0]    alarm_iv;
	logic [IvW-1:0]    period;
	logic [MagW-1:0]   alarm_lim;
	logic [MagW-1:0]   jump_lim;
	logic [ValW-1:0]   last_value;
	logic [CountW-1:0] count;
	res_t              due_reports[$];
	int unsigned       samples;
	int unsigned       reports;
	int unsigned       sends;
	int unsigned       failures;
	int unsigned       saturations;
	int unsigned       cause_hits[5];

	function new();
		normal_iv   = 16'd300;
		alarm_iv    = 16'd60;
		period      = 16'd60;
		alarm_lim   = 11'd750;
		jump_lim    = 11'd20;
		last_value  = '0;
		count       = 8'd1;
		samples     = 0;
		reports     = 0;
		sends       = 0;
		failures    = 0;
		saturations = 0;
		foreach (cause_hits[i]) cause_hits[i] = 0;
	endfunction

	function int unsigned pending();
		return due_reports.size();
	endfunction

	// Register write; unknown indexes fall through
	function void set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		case (idx)
			RegNormalIv: normal_iv = data;
			RegAlarmIv:  alarm_iv = data;
			RegPeriod:   period = data;
			RegAlarmLim: alarm_lim = data[MagW-1:0];
			RegJumpLim:  jump_lim = data[MagW-1:0];
			default: ;
		endcase
	endfunction

	// Median filter, code rewrite, step and interval decision
	function void record_sample(input logic [ValW-1:0] a, input logic [ValW-1:0] b,
			input logic [ValW-1:0] c, input logic ok);
		logic [ValW-1:0]   lo;
		logic [ValW-1:0]   hi;
		logic [ValW-1:0]   value;
		logic [ValW-1:0]   step;
		logic [CauseW-1:0] why;
		logic              hot;
		int unsigned       elapsed;
		res_t              word;

		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c <= lo) value = lo;
		else if (c >= hi) value = hi;
		else value = c;
		if (value == SuspectLo) value = ErrorLo;
		else if (value == SuspectHi) value = ErrorHi;

		// sign change: sum of magnitudes, else plain distance
		if (((value ^ last_value) & SignMask) != '0) step = (value + last_value) & MagMask;
		else step = (value >= last_value) ? value - last_value : last_value - value;
		last_value = value;

		hot = (value & MagMask) >= alarm_lim;
		if (!ok) why = CauseFail;
		else if (step >= jump_lim) why = CauseJump;
		else begin
			elapsed = count * period;
			if (elapsed >= (hot ? alarm_iv : normal_iv)) why = hot ? CauseAlarm : CauseNormal;
			else why = CauseHold;
		end

		if (why != CauseHold) count = 8'd1;
		else if (count != CountMax) begin
			count++;
			if (count == CountMax) saturations++;
		end

		word.send  = (why != CauseHold);
		word.value = value;
		word.cause = why;
		due_reports.push_back(word);
		samples++;
	endfunction

	function void check_report(input logic got_send, input logic [ValW-1:0] got_value,
			input logic [CauseW-1:0] got_cause);
		res_t want;

		reports++;
		if (due_reports.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected word: send %0d value %0d cause %0d",
					got_send, got_value, got_cause);
			return;
		end
		want = due_reports.pop_front();
		if (got_send !== want.send || got_value !== want.value || got_cause !== want.cause) begin
			failures++;
			if (failures <= 10)
				$display("word %0d mismatch: send %0d/%0d value %0d/%0d cause %0d/%0d (exp/got)",
					reports, want.send, got_send, want.value, got_value,
					want.cause, got_cause);
		end
		if (want.send) sends++;
		if (want.cause < 5) cause_hits[want.cause]++;
	endfunction
endclass

module testbench;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                push;
	logic                full;
	logic [ValW-1:0]     reading_first;
	logic [ValW-1:0]     reading_second;
	logic [ValW-1:0]     reading_third;
	logic                read_ok;
	logic                pop;
	logic                empty;
	logic                send_now;
	logic [ValW-1:0]     report_value;
	logic [CauseW-1:0]   cause;

	report_scoreboard    sb;
	int unsigned         feed_idle_pct;
	int unsigned         drain_idle_pct;
	int                  walk_mag;
	logic                walk_neg;

	temperature_report_scheduler dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.reading_first  (reading_first),
		.reading_second (reading_second),
		.reading_third  (reading_third),
		.read_ok        (read_ok),
		.pop            (pop),
		.empty          (empty),
		.send_now       (send_now),
		.report_value   (report_value),
		.cause          (cause)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Receiver: random pop per cycle
	always @(posedge clk) begin
		if (!arst_n) pop <= 1'b0;
		else pop <= ($urandom_range(99) >= drain_idle_pct);
	end

	// Handshake monitors; values seen here are the ones before the edge
	always @(posedge clk) begin
		if (arst_n && push && !full)
			sb.record_sample(reading_first, reading_second, reading_third, read_ok);
		if (arst_n && pop && !empty)
			sb.check_report(send_now, report_value, cause);
	end

	// One sample word; leaves push high after acceptance
	task automatic feed(input logic [ValW-1:0] a, input logic [ValW-1:0] b,
			input logic [ValW-1:0] c, input logic ok);
		while ($urandom_range(99) < feed_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push           <= 1'b1;
		reading_first  <= a;
		reading_second <= b;
		reading_third  <= c;
		read_ok        <= ok;
		do @(posedge clk); while (full);
	endtask

	// Hold the sender until every predicted word has been popped
	task automatic quiesce();
		push <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Write all five registers, then one index outside the map
	task automatic load_settings(input logic [CfgDataW-1:0] n_iv, input logic [CfgDataW-1:0] a_iv,
			input logic [CfgDataW-1:0] per, input logic [CfgDataW-1:0] a_lim,
			input logic [CfgDataW-1:0] j_lim);
		logic [CfgDataW-1:0] vals [5];
		logic [CfgIdxW-1:0]  regs [5];
		logic [CfgIdxW-1:0]  idx;
		logic [CfgDataW-1:0] data;
		int unsigned         j;

		vals = '{n_iv, a_iv, per, a_lim, j_lim};
		regs = '{RegNormalIv, RegAlarmIv, RegPeriod, RegAlarmLim, RegJumpLim};
		for (j = 0; j < 6; j++) begin
			if (j < 5) begin
				idx  = regs[j];
				data = vals[j];
			end else begin
				idx  = CfgIdxW'($urandom_range(RegJumpLim + 1, (1 << CfgIdxW) - 1));
				data = CfgDataW'($urandom);
			end
			cfg_wr_en <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= data;
			@(posedge clk);
			sb.set_reg(idx, data);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// Mostly a slow temperature walk with noisy readings and an occasional
	// outlier; the rest suspect codes, sign flips and raw noise. Calm mode
	// stays on the negative side in small steps so the count can saturate.
	task automatic feed_random(input bit calm);
		logic [ValW-1:0] r [3];
		logic [ValW-1:0] v;
		logic [ValW-1:0] t;
		logic            ok;
		int unsigned     mode;
		int unsigned     j;
		int unsigned     k;

		mode = calm ? 0 : $urandom_range(99);
		ok   = calm || ($urandom_range(15) != 0);
		if (mode >= 90) begin
			foreach (r[i]) r[i] = ValW'($urandom);
			ok = 1'($urandom_range(1));
		end else if (mode >= 80) begin
			v    = $urandom_range(1) ? SuspectHi : SuspectLo;
			r[0] = v;
			r[1] = v;
			r[2] = ValW'($urandom);
		end else begin
			if (mode >= 72) begin
				walk_neg = !walk_neg;
				walk_mag = $urandom_range(40);
			end else if (mode >= 66) begin
				walk_mag = int'(sb.alarm_lim) + int'($urandom_range(20)) - 10;
			end else begin
				walk_mag += int'($urandom_range(8)) - 4;
			end
			if (calm) walk_neg = 1'b1;
			if (walk_mag < (calm ? 4 : 0)) walk_mag = calm ? 4 : 0;
			if (walk_mag > (calm ? 2000 : 2047)) walk_mag = calm ? 2000 : 2047;
			v    = {walk_neg ? 5'b11111 : 5'b00000, MagW'(walk_mag)};
			r[0] = v;
			r[1] = v + ValW'($urandom_range(4)) - 16'd2;
			r[2] = ($urandom_range(3) == 0) ? ValW'($urandom) : v + ValW'($urandom_range(2));
		end
		// shuffle so the median can sit in any position
		for (j = 0; j < 3; j++) begin
			k    = $urandom_range(2);
			t    = r[j];
			r[j] = r[k];
			r[k] = t;
		end
		feed(r[0], r[1], r[2], ok);
	endtask

	// Field extremes, median positions, code rewrites, sign changes,
	// read failure with and without a large step, jump limit edges, alarm
	task automatic run_directed();
		feed(16'd0, 16'd0, 16'd0, 1'b1);
		feed(16'd5, 16'd9, 16'd7, 1'b1);
		feed(16'd3, 16'd7, 16'd12, 1'b1);
		feed(16'd12, 16'd3, 16'd7, 1'b1);
		feed(16'd7, 16'd12, 16'd3, 1'b1);
		feed(16'd850, 16'd850, 16'd1, 1'b1);
		feed(16'd1250, 16'd2, 16'd1250, 1'b1);
		feed(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		feed(16'hFFFF, 16'hFFFF, 16'hFFF0, 1'b0);
		feed(16'd0, 16'd0, 16'd0, 1'b0);
		feed(16'd20, 16'd20, 16'd20, 1'b1);
		feed(16'd39, 16'd39, 16'd39, 1'b1);
		feed(16'd760, 16'd760, 16'd760, 1'b1);
		feed(16'd770, 16'd770, 16'd770, 1'b1);
		feed(16'hF805, 16'hF805, 16'd3, 1'b1);
		feed(16'h8000, 16'h8000, 16'h8000, 1'b1);
		feed(16'hFFFF, 16'd0, 16'h8000, 1'b1);
		feed(16'h5555, 16'hAAAA, 16'h7FFF, 1'b1);
		feed(16'd850, 16'd0, 16'hFFFF, 1'b1);
		feed(16'd1250, 16'hFFFF, 16'd0, 1'b1);
	endtask

	initial begin
		int unsigned seg;
		int unsigned k;
		int unsigned n;

		sb             = new();
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		push           = 1'b0;
		pop            = 1'b0;
		reading_first  = '0;
		reading_second = '0;
		reading_third  = '0;
		read_ok        = 1'b0;
		feed_idle_pct  = 38;
		drain_idle_pct = 80;
		walk_mag       = 0;
		walk_neg       = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		for (seg = 0; seg < 6; seg++) begin
			quiesce();
			// receiver slow first, then sender slow, then free running
			if (seg < 2) begin
				feed_idle_pct  = 38;
				drain_idle_pct = 80;
			end else if (seg < 4) begin
				feed_idle_pct  = 80;
				drain_idle_pct = 38;
			end else begin
				feed_idle_pct  = 0;
				drain_idle_pct = 0;
			end
			case (seg)
				0: load_settings(16'd300, 16'd60, 16'd60, 16'd750, 16'd20);
				1: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd2047, 16'd2047);
				2: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
				3: load_settings(16'hFFFF, 16'hFFFF, 16'd1, 16'd2047, 16'd2047);
				4: load_settings(CfgDataW'($urandom_range(600, 100)),
					CfgDataW'($urandom_range(120, 30)),
					CfgDataW'($urandom_range(60, 10)),
					CfgDataW'($urandom_range(2047)),
					CfgDataW'($urandom_range(60, 5)));
				default: load_settings(CfgDataW'($urandom), CfgDataW'($urandom),
					CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom));
			endcase
			n = (seg == 3) ? 300 : 140;
			for (k = 0; k < n; k++) begin
				feed_random(seg == 3);
				if (k == n / 2) quiesce();
			end
		end

		// drain and let the pipeline settle
		push <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (8) @(posedge clk);

		$display("Ran %0d samples through 6 register settings, %0d words popped, %0d sends.",
			sb.samples, sb.reports, sb.sends);
		$display("Causes hold/normal/alarm/fail/jump: %0d/%0d/%0d/%0d/%0d; count saturated %0d times.",
			sb.cause_hits[0], sb.cause_hits[1], sb.cause_hits[2], sb.cause_hits[3],
			sb.cause_hits[4], sb.saturations);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d failures", sb.failures);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/trs_pkg.sv
hdl/trs_fifo.sv
hdl/trs_front.sv
hdl/trs_back.sv
hdl/temperature_report_scheduler.sv
tb/testbench.sv
